// ----- design/sha_pkg.sv -----
// shared types, constants and round functions of the sha-256 stream hasher
`timescale 1ns / 1ps
package sha_pkg;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] data_byte;
    logic       is_last;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  // command from front to back
  typedef enum logic [1:0] {
    CMD_BLOCK = 2'd0,
    CMD_FINAL = 2'd1
  } sha_cmd_e;

  typedef struct packed {
    sha_cmd_e     cmd;
    logic [511:0] block;
  } sha_job_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_ROUND = 2'd1,
    BK_ADD   = 2'd2,
    BK_EMIT  = 2'd3
  } sha_bk_state_e;

  typedef enum logic [1:0] {
    FR_FILL = 2'd0,
    FR_PAD2 = 2'd1
  } sha_fr_state_e;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int BLOCK_BYTES = 64;
  localparam int LEN_POS = 56;

  localparam logic [255:0] INIT_CHAIN = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- design/sha_front.sv -----
// front end: packs bytes into blocks, pads at message end, queues jobs for the back end
`timescale 1ns / 1ps
module sha_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sha_pkg::sha_in_t  in_data,
  output logic              job_valid,
  input  logic              job_stall,
  output sha_pkg::sha_job_t job_data
);
  import sha_pkg::*;

  logic [511:0] buf_r, buf_nxt;
  logic [5:0]   cnt_r, cnt_nxt;
  logic [60:0]  msg_r, msg_nxt;
  sha_fr_state_e st_r, st_nxt;
  logic [63:0]  bitlen_r, bitlen_nxt;
  // second block after overflow: marker is in it only when the data filled a block
  logic         pad_mark_r;

  // two-entry job queue
  sha_job_t q_r [2];
  logic [1:0] q_cnt_r;
  logic       q_rd_r, q_wr_r;

  logic       push;
  sha_job_t   push_job;
  logic       pop;
  logic       full;
  logic       acc;

  logic [511:0] wbuf;
  logic [5:0]   pos;
  logic [6:0]   pos_inc;
  logic [60:0]  msg_inc;

  assign full = (q_cnt_r == 2'd2);
  assign in_stall = full || (st_r == FR_PAD2);
  assign acc = in_valid && !in_stall;
  assign pop = job_valid && !job_stall;
  assign job_valid = (q_cnt_r != 2'd0);
  assign job_data = q_r[q_rd_r];

  always_comb begin
    wbuf = buf_r;
    pos = cnt_r;
    msg_inc = msg_r + 61'(in_data.has_byte);
    pos_inc = 7'(cnt_r) + 7'(in_data.has_byte);
    if (in_data.has_byte) begin
      wbuf[511 - 8 * pos -: 8] = in_data.data_byte;
    end
    pos = pos_inc[5:0];
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    msg_nxt = msg_r;
    st_nxt = st_r;
    bitlen_nxt = bitlen_r;
    push = 1'b0;
    push_job.cmd = CMD_BLOCK;
    push_job.block = wbuf;
    if (st_r == FR_PAD2) begin
      if (!full) begin
        push = 1'b1;
        push_job.cmd = CMD_FINAL;
        if (pad_mark_r) begin
          push_job.block = {PAD_BYTE, 440'b0, bitlen_r};
        end else begin
          push_job.block = {448'b0, bitlen_r};
        end
        st_nxt = FR_FILL;
      end
    end else if (acc) begin
      msg_nxt = msg_inc;
      if (!in_data.is_last) begin
        cnt_nxt = pos;
        buf_nxt = wbuf;
        if (pos_inc[6]) begin
          push = 1'b1;
        end
      end else begin
        msg_nxt = '0;
        cnt_nxt = '0;
        bitlen_nxt = {msg_inc, 3'b000};
        if (pos_inc[6]) begin
          // full block, then a block of padding and length
          push = 1'b1;
          st_nxt = FR_PAD2;
          bitlen_nxt = {msg_inc, 3'b000};
        end else begin
          for (int b = 0; b < BLOCK_BYTES; b++) begin
            if (b == int'(pos)) begin
              wbuf[511 - 8 * b -: 8] = PAD_BYTE;
            end else if (b > int'(pos)) begin
              wbuf[511 - 8 * b -: 8] = 8'h00;
            end
          end
          push = 1'b1;
          if (int'(pos) >= LEN_POS) begin
            push_job.block = wbuf;
            st_nxt = FR_PAD2;
          end else begin
            push_job.cmd = CMD_FINAL;
            push_job.block = {wbuf[511:64], msg_inc, 3'b000};
          end
        end
        if (pos_inc[6]) begin
          // pad block starts with the marker
          bitlen_nxt = {msg_inc, 3'b000};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_mark_r <= 1'b0;
    end else if (acc && in_data.is_last) begin
      pad_mark_r <= pos_inc[6];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      msg_r <= '0;
      st_r <= FR_FILL;
      q_cnt_r <= '0;
      q_rd_r <= 1'b0;
      q_wr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      msg_r <= msg_nxt;
      st_r <= st_nxt;
      q_cnt_r <= q_cnt_r + 2'(push) - 2'(pop);
      if (push) q_wr_r <= !q_wr_r;
      if (pop) q_rd_r <= !q_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    bitlen_r <= bitlen_nxt;
    if (push) begin
      q_r[q_wr_r] <= push_job;
    end
  end
endmodule

// ----- design/sha_back.sv -----
// back end: 64-round compression, one round per cycle, and digest word output
`timescale 1ns / 1ps
module sha_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_stall,
  input  sha_pkg::sha_job_t job_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sha_pkg::sha_out_t out_data
);
  import sha_pkg::*;

  sha_bk_state_e st_r, st_nxt;
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [5:0]  rnd_r;
  logic        fin_r;
  logic [2:0]  idx_r;

  logic [31:0] t1, t2, s0, s1, wn, wcur;
  logic take;
  logic emit_go;

  assign job_stall = (st_r != BK_IDLE);
  assign take = job_valid && (st_r == BK_IDLE);
  assign out_valid = (st_r == BK_EMIT);
  assign emit_go = out_valid && !out_stall;
  assign out_data.digest_word = h_r[idx_r];
  assign out_data.word_index = idx_r;
  assign out_data.last_word = (idx_r == 3'd7);

  always_comb begin
    wcur = w_r[0];
    s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    wn = w_r[0] + s0 + w_r[9] + s1;
    t1 = v_r[7] + (rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25))
         + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + round_k(rnd_r) + wcur;
    t2 = (rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22))
         + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: if (take) st_nxt = BK_ROUND;
      BK_ROUND: if (rnd_r == 6'd63) st_nxt = BK_ADD;
      BK_ADD: st_nxt = fin_r ? BK_EMIT : BK_IDLE;
      BK_EMIT: if (emit_go && idx_r == 3'd7) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      rnd_r <= '0;
      idx_r <= '0;
      fin_r <= 1'b0;
      for (int i = 0; i < 8; i++) h_r[i] <= INIT_CHAIN[255 - 32 * i -: 32];
    end else begin
      st_r <= st_nxt;
      case (st_r)
        BK_IDLE: begin
          rnd_r <= '0;
          idx_r <= '0;
          if (take) fin_r <= (job_data.cmd == CMD_FINAL);
        end
        BK_ROUND: rnd_r <= rnd_r + 6'd1;
        BK_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
        end
        BK_EMIT: begin
          if (emit_go) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              for (int i = 0; i < 8; i++) h_r[i] <= INIT_CHAIN[255 - 32 * i -: 32];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < 16; i++) w_r[i] <= job_data.block[511 - 32 * i -: 32];
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (st_r == BK_ROUND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
      w_r[15] <= wn;
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end
endmodule

// ----- design/sha256_stream_hasher.sv -----
// top level of the sha-256 stream hasher
`timescale 1ns / 1ps
// sha-256 over a byte stream
// input beat: one optional message byte plus an end-of-message flag, valid/stall
// handshake. bytes are accepted one per cycle while the two-entry block queue
// has room and no padding block is pending; a beat that completes a block or
// ends the message pushes a job. the back end runs one round per cycle; each
// 64-byte block takes a load, 64 rounds and one chaining add, so sustained
// input is about one byte per cycle, set by the single round unit.
// at message end one or two padded blocks are hashed, then eight output beats
// carry the digest words, index 0 first, last_word on index 7. the first digest
// word waits for any jobs still ahead of it and for output stall time.
// while out_stall is high the current word holds and no further block is
// started; input keeps filling until the queue is full.
// after the eighth word the chaining state returns to the initial values.
// reset (rst_n low, synchronous) empties the queue and restarts the message.
module sha256_stream_hasher (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sha_pkg::sha_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sha_pkg::sha_out_t out_data
);
  import sha_pkg::*;

  logic     job_valid;
  logic     job_stall;
  sha_job_t job_data;

  sha_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .job_valid, .job_stall, .job_data
  );

  sha_back u_back (
    .clk, .rst_n, .job_valid, .job_stall, .job_data,
    .out_valid, .out_stall, .out_data
  );
endmodule

// ----- design/sha_checker.sv -----
// port-level checks for the sha-256 stream hasher
`timescale 1ns / 1ps
module sha_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input sha_pkg::sha_out_t out_data
);
  import sha_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output changed");

  a_next_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_word |=>
      out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
    else $error("digest words not contiguous");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.last_word == (out_data.word_index == 3'd7))
    else $error("last_word mismatch");

  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last_word |=> !out_valid)
    else $error("digest follows digest without compression");
endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_data
);
